// File: rtl/core/plc_pkg.sv
// ----------------------------------------------------------------------
// plc_pkg
// Types and fixed constants shared by the loop-cutoff core.
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

package plc_pkg;

    // width of the cutoff distance register (unsigned Q15.16)
    localparam int DIST_W = 31;
    // width of the squared cutoff distance
    localparam int THR_W  = 2 * DIST_W;

    typedef enum logic [2:0] {
        ST_LOAD,      // take points, idle between polylines
        ST_REF,       // read the node under test
        ST_SCAN,      // stream candidates through the distance pipeline
        ST_EMIT_RD,   // read a surviving node and its link
        ST_EMIT_OUT   // present the node, follow the link
    } plc_state_t;

    // status of the distance pipeline towards the sequencer
    typedef struct packed {
        logic hit;    // first close candidate of this scan is at the tail
        logic busy;   // a candidate is still in flight
    } plc_pipe_stat_t;

endpackage

// File: rtl/core/plc_ram.sv
// ----------------------------------------------------------------------
// plc_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

module plc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/plc_dist_pipe.sv
// ----------------------------------------------------------------------
// plc_dist_pipe
// Four-stage squared-distance compare of a candidate node against the
// node under test; reports the first candidate closer than the cutoff.
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

module plc_dist_pipe #(
    parameter int COORD_BITS = 32,
    parameter int IDX_W      = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [IDX_W-1:0]            in_idx,
    input  logic [COORD_BITS-1:0]       cand_x,
    input  logic [COORD_BITS-1:0]       cand_y,
    input  logic [COORD_BITS-1:0]       ref_x,
    input  logic [COORD_BITS-1:0]       ref_y,
    input  logic [plc_pkg::THR_W-1:0]   thr_sq,
    input  logic                        flush,
    output plc_pkg::plc_pipe_stat_t     stat,
    output logic [IDX_W-1:0]            hit_idx
);

    localparam int C      = COORD_BITS;
    localparam int HALF   = (C + 1) / 2;
    localparam int HI_W   = C - HALF;
    localparam int LL_W   = 2 * HALF;
    localparam int LH_W   = HALF + HI_W;
    localparam int HH_W   = 2 * HI_W;
    localparam int SQ_W   = 2 * C;
    localparam int SUM_W  = SQ_W + 1;
    localparam int CMP_W  = (SUM_W > plc_pkg::THR_W) ? SUM_W : plc_pkg::THR_W;
    localparam logic [C-1:0] SIGN = {1'b1, {(C-1){1'b0}}};

    // stage 1: absolute differences
    logic             v1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [C-1:0]     dx_reg;
    logic [C-1:0]     dy_reg;
    logic [C-1:0]     dx_next;
    logic [C-1:0]     dy_next;

    // stage 2: partial products
    logic             v2_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [LL_W-1:0]  xll_reg;
    logic [LH_W-1:0]  xlh_reg;
    logic [HH_W-1:0]  xhh_reg;
    logic [LL_W-1:0]  yll_reg;
    logic [LH_W-1:0]  ylh_reg;
    logic [HH_W-1:0]  yhh_reg;

    // stage 3: squares
    logic             v3_reg;
    logic [IDX_W-1:0] idx3_reg;
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;

    // stage 4: compare
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [CMP_W-1:0] sum;
    logic             close;

    function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
        logic [C-1:0] ua;
        logic [C-1:0] ub;
        ua = a ^ SIGN;
        ub = b ^ SIGN;
        return (ua >= ub) ? (ua - ub) : (ub - ua);
    endfunction

    function automatic logic [SQ_W-1:0] join_sq(input logic [LL_W-1:0] ll,
                                               input logic [LH_W-1:0] lh,
                                               input logic [HH_W-1:0] hh);
        return (SQ_W'(hh) << (2 * HALF)) + (SQ_W'(lh) << (HALF + 1)) + SQ_W'(ll);
    endfunction

    assign dx_next = abs_diff(cand_x, ref_x);
    assign dy_next = abs_diff(cand_y, ref_y);

    assign sum   = CMP_W'(sqx_reg) + CMP_W'(sqy_reg);
    assign close = sum < CMP_W'(thr_sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            // drop everything in flight once the first hit is taken
            v1_reg  <= in_valid & ~flush;
            v2_reg  <= v1_reg & ~flush;
            v3_reg  <= v2_reg & ~flush;
            hit_reg <= v3_reg & close & ~flush;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg    <= in_idx;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;

        idx2_reg    <= idx1_reg;
        xll_reg     <= LL_W'(dx_reg[HALF-1:0]) * LL_W'(dx_reg[HALF-1:0]);
        xlh_reg     <= LH_W'(dx_reg[HALF-1:0]) * LH_W'(dx_reg[C-1:HALF]);
        xhh_reg     <= HH_W'(dx_reg[C-1:HALF]) * HH_W'(dx_reg[C-1:HALF]);
        yll_reg     <= LL_W'(dy_reg[HALF-1:0]) * LL_W'(dy_reg[HALF-1:0]);
        ylh_reg     <= LH_W'(dy_reg[HALF-1:0]) * LH_W'(dy_reg[C-1:HALF]);
        yhh_reg     <= HH_W'(dy_reg[C-1:HALF]) * HH_W'(dy_reg[C-1:HALF]);

        idx3_reg    <= idx2_reg;
        sqx_reg     <= join_sq(xll_reg, xlh_reg, xhh_reg);
        sqy_reg     <= join_sq(yll_reg, ylh_reg, yhh_reg);

        hit_idx_reg <= idx3_reg;
    end

    assign stat.hit  = hit_reg;
    assign stat.busy = v1_reg | v2_reg | v3_reg;
    assign hit_idx   = hit_idx_reg;

endmodule

// File: rtl/core/polyline_loop_cutoff_core.sv
// ----------------------------------------------------------------------
// polyline_loop_cutoff_core
// Loop-cutoff filter for a 2-D polyline held in on-chip RAM.
// ----------------------------------------------------------------------
// Points are taken one per cycle while busy is low. The point with
// final_point set starts the pass; busy then stays high until the last
// surviving node has been sent. Each node i of the pass costs one RAM read
// plus a stream of candidate reads j = i+2 .. len-1, one per cycle, that
// runs through a four-stage squared-distance pipeline; the scan for node i
// ends on the first close candidate or after the stream drains. Deleted
// runs are never copied: each node under test writes the index of its
// successor into a link RAM. Results then leave by walking the links, each
// beat taking a read state (ST_EMIT_RD) and an output state (ST_EMIT_OUT).
// kept_valid marks each beat for exactly one cycle and the receiver cannot
// hold it off. Points beyond MAX_NODES are dropped and flagged. The cutoff
// distance register accepts a write in every cycle and must only be written
// between polylines.
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

module polyline_loop_cutoff_core #(
    parameter int MAX_NODES  = 64,
    parameter int COORD_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // point input
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      point_x,
    input  logic signed [COORD_BITS-1:0]      point_y,
    input  logic                              final_point,

    // surviving nodes
    output logic                              kept_valid,
    output logic signed [COORD_BITS-1:0]      kept_x,
    output logic signed [COORD_BITS-1:0]      kept_y,
    output logic                              end_of_run,
    output logic                              cutoff_seen,
    output logic                              overflowed,

    // cutoff distance register
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [plc_pkg::DIST_W-1:0]        cfg_data
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int EW = CW + 1;

    plc_pkg::plc_state_t state_reg;
    plc_pkg::plc_state_t state_next;

    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic [AW-1:0]                  cur_reg;
    logic [AW-1:0]                  cur_next;
    logic [CW-1:0]                  k_reg;
    logic [CW-1:0]                  k_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic                           cut_reg;
    logic                           cut_next;

    logic [plc_pkg::DIST_W-1:0]     cutoff_reg;
    logic [plc_pkg::THR_W-1:0]      thr_sq_reg;

    logic                           ref_cap_reg;
    logic [COORD_BITS-1:0]          ref_x_reg;
    logic [COORD_BITS-1:0]          ref_y_reg;
    logic                           cand_v_reg;
    logic [AW-1:0]                  cand_idx_reg;

    logic                           kept_valid_reg;
    logic [COORD_BITS-1:0]          kept_x_reg;
    logic [COORD_BITS-1:0]          kept_y_reg;
    logic                           end_of_run_reg;
    logic                           cutoff_seen_reg;
    logic                           overflowed_reg;

    // RAM ports
    logic                           xy_we;
    logic [AW-1:0]                  xy_raddr;
    logic [COORD_BITS-1:0]          x_rdata;
    logic [COORD_BITS-1:0]          y_rdata;
    logic                           link_we;
    logic [AW-1:0]                  link_wdata;
    logic [AW-1:0]                  link_rdata;

    // pipeline status
    plc_pkg::plc_pipe_stat_t        pipe_stat;
    logic [AW-1:0]                  hit_idx;
    logic                           pipe_flush;

    logic                           accept;
    logic                           full;
    logic [CW-1:0]                  len_after;
    logic                           scan_issue;
    logic                           scan_miss;
    logic [AW-1:0]                  succ;
    logic                           succ_tested;
    logic                           cur_tested;
    logic                           cur_last;

    assign accept    = start & (state_reg == plc_pkg::ST_LOAD);
    assign full      = (count_reg == CW'(MAX_NODES));
    assign len_after = full ? count_reg : count_reg + CW'(1);

    // keep issuing candidates until the tail or the first hit
    assign scan_issue = ~pipe_stat.hit & (k_reg < count_reg);
    assign scan_miss  = ~pipe_stat.hit & ~scan_issue & ~cand_v_reg & ~pipe_stat.busy;

    assign succ        = pipe_stat.hit ? hit_idx : cur_reg + AW'(1);
    // a node is tested while at least two nodes follow it
    assign succ_tested = (EW'(succ) + EW'(3)) <= EW'(count_reg);
    assign cur_tested  = (EW'(cur_reg) + EW'(3)) <= EW'(count_reg);
    assign cur_last    = (CW'(cur_reg) + CW'(1)) == count_reg;

    assign pipe_flush = (state_reg == plc_pkg::ST_SCAN) & pipe_stat.hit;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        k_next     = k_reg;
        ovf_next   = ovf_reg;
        cut_next   = cut_reg;
        link_we    = 1'b0;
        link_wdata = succ;
        xy_we      = 1'b0;
        xy_raddr   = cur_reg;

        case (state_reg)
            plc_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    // store the point, or drop it and flag the overflow
                    xy_we      = ~full;
                    count_next = len_after;
                    ovf_next   = ovf_reg | full;
                    if (final_point)
                    begin
                        cur_next = '0;
                        if (len_after >= CW'(3))
                        begin
                            state_next = plc_pkg::ST_REF;
                        end
                        else
                        begin
                            state_next = plc_pkg::ST_EMIT_RD;
                        end
                    end
                end
            end

            plc_pkg::ST_REF:
            begin
                k_next     = CW'(cur_reg) + CW'(2);
                state_next = plc_pkg::ST_SCAN;
            end

            plc_pkg::ST_SCAN:
            begin
                xy_raddr = k_reg[AW-1:0];
                if (scan_issue)
                begin
                    k_next = k_reg + CW'(1);
                end
                if (pipe_stat.hit | scan_miss)
                begin
                    // record the successor and move on to it
                    link_we  = 1'b1;
                    cut_next = cut_reg | pipe_stat.hit;
                    if (succ_tested)
                    begin
                        cur_next   = succ;
                        state_next = plc_pkg::ST_REF;
                    end
                    else
                    begin
                        cur_next   = '0;
                        state_next = plc_pkg::ST_EMIT_RD;
                    end
                end
            end

            plc_pkg::ST_EMIT_RD:
            begin
                state_next = plc_pkg::ST_EMIT_OUT;
            end

            plc_pkg::ST_EMIT_OUT:
            begin
                if (cur_last)
                begin
                    // polyline done: clear for the next one
                    count_next = '0;
                    ovf_next   = 1'b0;
                    cut_next   = 1'b0;
                    state_next = plc_pkg::ST_LOAD;
                end
                else
                begin
                    // untested tail nodes follow one another directly
                    cur_next   = cur_tested ? link_rdata : cur_reg + AW'(1);
                    state_next = plc_pkg::ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = plc_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= plc_pkg::ST_LOAD;
            count_reg      <= '0;
            cur_reg        <= '0;
            k_reg          <= '0;
            ovf_reg        <= 1'b0;
            cut_reg        <= 1'b0;
            cutoff_reg     <= plc_pkg::DIST_W'(65536);
            ref_cap_reg    <= 1'b0;
            cand_v_reg     <= 1'b0;
            kept_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cur_reg        <= cur_next;
            k_reg          <= k_next;
            ovf_reg        <= ovf_next;
            cut_reg        <= cut_next;
            if (cfg_valid)
            begin
                cutoff_reg <= cfg_data;
            end
            ref_cap_reg    <= (state_reg == plc_pkg::ST_REF);
            cand_v_reg     <= (state_reg == plc_pkg::ST_SCAN) & scan_issue;
            kept_valid_reg <= (state_reg == plc_pkg::ST_EMIT_OUT);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        thr_sq_reg   <= plc_pkg::THR_W'(cutoff_reg) * plc_pkg::THR_W'(cutoff_reg);
        cand_idx_reg <= k_reg[AW-1:0];
        // the first scan cycle sees the node under test on the read port
        if (ref_cap_reg)
        begin
            ref_x_reg <= x_rdata;
            ref_y_reg <= y_rdata;
        end
        if (state_reg == plc_pkg::ST_EMIT_OUT)
        begin
            kept_x_reg      <= x_rdata;
            kept_y_reg      <= y_rdata;
            end_of_run_reg  <= cur_last;
            cutoff_seen_reg <= cut_reg;
            overflowed_reg  <= ovf_reg;
        end
    end

    plc_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (COORD_BITS)
    ) u_x_ram (
        .clk   (clk),
        .we    (xy_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (point_x),
        .raddr (xy_raddr),
        .rdata (x_rdata)
    );

    plc_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (COORD_BITS)
    ) u_y_ram (
        .clk   (clk),
        .we    (xy_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (point_y),
        .raddr (xy_raddr),
        .rdata (y_rdata)
    );

    plc_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (AW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (cur_reg),
        .wdata (link_wdata),
        .raddr (cur_reg),
        .rdata (link_rdata)
    );

    plc_dist_pipe #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (AW)
    ) u_dist_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cand_v_reg),
        .in_idx   (cand_idx_reg),
        .cand_x   (x_rdata),
        .cand_y   (y_rdata),
        .ref_x    (ref_x_reg),
        .ref_y    (ref_y_reg),
        .thr_sq   (thr_sq_reg),
        .flush    (pipe_flush),
        .stat     (pipe_stat),
        .hit_idx  (hit_idx)
    );

    assign busy        = (state_reg != plc_pkg::ST_LOAD);
    assign cfg_ready   = 1'b1;
    assign kept_valid  = kept_valid_reg;
    assign kept_x      = kept_x_reg;
    assign kept_y      = kept_y_reg;
    assign end_of_run  = end_of_run_reg;
    assign cutoff_seen = cutoff_seen_reg;
    assign overflowed  = overflowed_reg;

endmodule

// File: rtl/core/plc_checker.sv
// ----------------------------------------------------------------------
// plc_checker
// Port-level checks on the loop-cutoff core, bound to the top level.
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

module plc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic final_point,
    input logic kept_valid,
    input logic end_of_run
);

    // a pass only starts from an accepted final point
    a_busy_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && final_point))
        else $error("busy rose without a final point");

    // beats only leave during a pass
    a_beat_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        kept_valid |-> $past(busy))
        else $error("result beat outside a pass");

    // the last beat closes the run
    a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (kept_valid && end_of_run) |=> (!kept_valid && !busy))
        else $error("activity after the last beat");

    // more beats to come keep the block busy
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (kept_valid && !end_of_run) |=> busy)
        else $error("run ended without a last beat");

endmodule

bind polyline_loop_cutoff_core plc_checker u_plc_checker (.*);

// File: verif/tb.sv
// ----------------------------------------------------------------------
// tb
// Self-checking bench for the polyline loop-cutoff core.
// ----------------------------------------------------------------------
// Polylines go in one point per beat on the start/busy port. A scoreboard
// keeps its own copy of the node chain and the cutoff distance. On each
// final point it prunes loops with an exact squared-distance compare and
// queues the surviving nodes. Every kept_valid beat is then checked against
// the oldest queued node. A short directed set covers the edge cases.
// Random polylines follow, built as walks that wander back on themselves.
// The distance register is rewritten between polylines.
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

class cutoff_scoreboard;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } node_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        logic               cut;
        logic               ovf;
    } kept_t;

    int                        capacity;
    node_t                     chain[$];
    kept_t                     kept_due[$];
    bit                        dropped;
    bit                        looped;
    bit [plc_pkg::DIST_W-1:0]  cutoff;
    int                        errors;
    int                        shown;
    int                        points;
    int                        polylines;
    int                        beats;
    int                        looped_runs;
    int                        dropped_runs;
    int                        writes;

    function new(int depth);
        capacity = depth;
        cutoff   = plc_pkg::DIST_W'(65536);
    endfunction

    function void set_cutoff(bit [plc_pkg::DIST_W-1:0] d);
        cutoff = d;
        writes++;
    endfunction

    // |a - b| of two signed coordinates, needs 33 bits
    function bit [32:0] span(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return d[32:0];
    endfunction

    function bit close_pair(node_t a, node_t b);
        bit [65:0] ex;
        bit [65:0] ey;
        bit [65:0] lim;
        ex  = 66'(span(a.x, b.x));
        ey  = 66'(span(a.y, b.y));
        lim = 66'(cutoff);
        return (ex * ex + ey * ey) < (lim * lim);
    endfunction

    // drop the nodes between i and its first close partner j >= i+2
    function void prune_loops();
        int i;
        int j;
        int hit;
        i = 0;
        while (chain.size() >= 3 && i <= chain.size() - 3)
        begin
            hit = -1;
            for (j = i + 2; j < chain.size() && hit < 0; j++)
                if (close_pair(chain[i], chain[j]))
                    hit = j;
            if (hit >= 0)
            begin
                repeat (hit - i - 1) chain.delete(i + 1);
                looped = 1'b1;
            end
            i++;
        end
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y, logic last);
        node_t n;
        kept_t k;
        int    idx;
        points++;
        if (chain.size() < capacity)
        begin
            n.x = x;
            n.y = y;
            chain.insert(chain.size(), n);
        end
        else
            dropped = 1'b1;
        if (!last)
            return;
        prune_loops();
        polylines++;
        looped_runs  += looped;
        dropped_runs += dropped;
        for (idx = 0; idx < chain.size(); idx++)
        begin
            k.x    = chain[idx].x;
            k.y    = chain[idx].y;
            k.last = (idx == chain.size() - 1);
            k.cut  = looped;
            k.ovf  = dropped;
            kept_due.insert(kept_due.size(), k);
        end
        chain.delete();
        dropped = 1'b0;
        looped  = 1'b0;
    endfunction

    task report(string what);
        errors++;
        if (shown < 100)
        begin
            shown++;
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    task check_kept(logic signed [31:0] x, logic signed [31:0] y,
                    logic last, logic cut, logic ovf);
        kept_t k;
        beats++;
        if (kept_due.size() == 0)
        begin
            report($sformatf("beat %0d (%h,%h) with no node due", beats, x, y));
            return;
        end
        k = kept_due.pop_front();
        if (x !== k.x)
            report($sformatf("beat %0d kept_x %h, want %h", beats, x, k.x));
        if (y !== k.y)
            report($sformatf("beat %0d kept_y %h, want %h", beats, y, k.y));
        if (last !== k.last)
            report($sformatf("beat %0d end_of_run %b, want %b", beats, last, k.last));
        if (cut !== k.cut)
            report($sformatf("beat %0d cutoff_seen %b, want %b", beats, cut, k.cut));
        if (ovf !== k.ovf)
            report($sformatf("beat %0d overflowed %b, want %b", beats, ovf, k.ovf));
    endtask

    function int pending();
        return kept_due.size();
    endfunction

endclass

module tb;

    localparam int DEPTH       = 64;
    localparam int QUIET_LIMIT = 20000;
    localparam int RAND_POINTS = 250;

    // handy Q16.16 values
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINC = 32'sh8000_0000;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [31:0]          point_x;
    logic signed [31:0]          point_y;
    logic                        final_point;
    logic                        kept_valid;
    logic signed [31:0]          kept_x;
    logic signed [31:0]          kept_y;
    logic                        end_of_run;
    logic                        cutoff_seen;
    logic                        overflowed;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [plc_pkg::DIST_W-1:0]  cfg_data;

    cutoff_scoreboard sb;
    int               quiet;

    polyline_loop_cutoff_core #(
        .MAX_NODES  (DEPTH),
        .COORD_BITS (32)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .point_x     (point_x),
        .point_y     (point_y),
        .final_point (final_point),
        .kept_valid  (kept_valid),
        .kept_x      (kept_x),
        .kept_y      (kept_y),
        .end_of_run  (end_of_run),
        .cutoff_seen (cutoff_seen),
        .overflowed  (overflowed),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every kept beat on the edge that ends it; the receiver has no
    // way to stall, so nothing is ever held off here.
    always @(posedge clk)
    begin
        if (rst_n && kept_valid)
            sb.check_kept(kept_x, kept_y, end_of_run, cutoff_seen, overflowed);
    end

    // Count cycles in which no beat moves on any port; give up when the
    // count reaches the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || kept_valid || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("status: fail");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_edge();
        case ($urandom_range(0, 3))
            0:       return MAXC;
            1:       return MINC;
            2:       return 32'sh0;
            default: return -32'sh1;
        endcase
    endfunction

    function automatic logic signed [31:0] wander(logic signed [31:0] from,
                                                  int unsigned reach);
        return from + $signed($urandom_range(0, 2 * reach)) - $signed(reach);
    endfunction

    function automatic logic [plc_pkg::DIST_W-1:0] pick_cutoff();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return plc_pkg::DIST_W'(65536);
            3:       return plc_pkg::DIST_W'($urandom_range(1, 1 << 20));
            4:       return plc_pkg::DIST_W'($urandom_range(1 << 20, 1 << 28));
            default: return plc_pkg::DIST_W'($urandom);
        endcase
    endfunction

    // Mostly short polylines, a few that fill or overrun the store.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return $urandom_range(1, 8);
        else if (r < 18)
            return $urandom_range(9, 24);
        return $urandom_range(DEPTH - 8, DEPTH + 6);
    endfunction

    // Offer one point; hold it until the core takes it. Entered and left on
    // a falling edge, with start left high so that a following point with no
    // gap goes out without a dip.
    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        point_x     <= x;
        point_y     <= y;
        final_point <= last;
        do
            @(posedge clk);
        while (busy);
        sb.note_point(x, y, last);
        @(negedge clk);
    endtask

    // Drop start, then hold until every node due has come out and the core
    // is idle again, then let the pass wind down.
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Only ever called with the core idle and start already low.
    task automatic write_cutoff(input logic [plc_pkg::DIST_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_cutoff(d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Build a walk whose steps are about twice the cutoff, so that most
    // neighbours survive, and let it jump back near earlier nodes now and
    // then so that loops appear. A sprinkling of wild and extreme points
    // keeps every coordinate bit moving.
    task automatic run_polyline(input int len);
        logic signed [31:0] xs[$];
        logic signed [31:0] ys[$];
        logic signed [31:0] x;
        logic signed [31:0] y;
        int unsigned        reach;
        int                 p;
        int                 r;
        int                 idx;
        if (sb.cutoff == 0)
            reach = 65536;
        else if (sb.cutoff > 31'h0800_0000)
            reach = 32'h1000_0000;
        else
            reach = 2 * sb.cutoff;
        if ($urandom_range(0, 3) == 0)
        begin
            x = $urandom;
            y = $urandom;
        end
        else
        begin
            x = wander(32'sh0, 1 << 22);
            y = wander(32'sh0, 1 << 22);
        end
        for (p = 0; p < len; p++)
        begin
            r = $urandom_range(0, 15);
            if (p == 0)
                ;
            else if (r == 0)
            begin
                x = $urandom;
                y = $urandom;
            end
            else if (r == 1)
            begin
                x = pick_edge();
                y = pick_edge();
            end
            else if (r <= 4)
            begin
                // land close to an earlier node
                idx = $urandom_range(0, p - 1);
                x   = wander(xs[idx], reach / 4);
                y   = wander(ys[idx], reach / 4);
            end
            else
            begin
                x = wander(x, reach);
                y = wander(y, reach);
            end
            xs.insert(xs.size(), x);
            ys.insert(ys.size(), y);
            send_point(x, y, p == len - 1);
        end
        wait_drained();
    endtask

    initial
    begin
        int sent;
        int poly;
        int len;

        sb          = new(DEPTH);
        rst_n       = 1'b0;
        start       = 1'b0;
        point_x     = '0;
        point_y     = '0;
        final_point = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed ----
        write_cutoff(plc_pkg::DIST_W'(65536));

        // single point: passes straight through, extreme corner
        send_point(MAXC, MINC, 1'b1);
        wait_drained();

        // two points at opposite corners of the coordinate range
        send_point(MINC, MINC, 1'b0);
        send_point(MAXC, MAXC, 1'b1);
        wait_drained();

        // square that comes back within 0.5 of its start: the corners go
        send_point(32'sh0,    32'sh0,    1'b0);
        send_point(10 * ONE,  32'sh0,    1'b0);
        send_point(10 * ONE,  10 * ONE,  1'b0);
        send_point(32'sh0,    ONE / 2,   1'b0);
        send_point(5 * ONE,   5 * ONE,   1'b1);
        wait_drained();

        // open triangle, nothing close enough
        send_point(32'sh0,    32'sh0,    1'b0);
        send_point(5 * ONE,   32'sh0,    1'b0);
        send_point(32'sh0,    5 * ONE,   1'b1);
        wait_drained();

        // zero distance: even coincident nodes are kept
        write_cutoff('0);
        send_point(ONE, ONE, 1'b0);
        send_point(ONE, ONE, 1'b0);
        send_point(ONE, ONE, 1'b1);
        wait_drained();

        // largest distance, with corner points that are still too far
        write_cutoff('1);
        send_point(32'sh0,    32'sh0,    1'b0);
        send_point(100 * ONE, 32'sh0,    1'b0);
        send_point(MINC,      MINC,      1'b0);
        send_point(5 * ONE,   32'sh0,    1'b0);
        send_point(MAXC,      MAXC,      1'b1);
        wait_drained();

        // distance exactly at the cutoff is not below it
        write_cutoff(plc_pkg::DIST_W'(65536));
        send_point(32'sh0,    32'sh0,    1'b0);
        send_point(32'sh0,    ONE / 2,   1'b0);
        send_point(ONE,       32'sh0,    1'b1);
        wait_drained();

        // ---- random ----
        // The second random polyline always overruns the store, so that its
        // final point is dropped yet still triggers the pass.
        sent = 0;
        poly = 0;
        while (sent < RAND_POINTS)
        begin
            if (poly > 0 && $urandom_range(0, 3) == 0)
                write_cutoff(pick_cutoff());
            len = (poly == 1) ? DEPTH + 2 : pick_length();
            run_polyline(len);
            sent += len;
            poly++;
        end

        // allow the core's tail latency before the verdict
        repeat (20) @(negedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d nodes never came out", sb.pending()));

        $display("ran %0d polylines from %0d points, %0d kept nodes checked",
                 sb.polylines, sb.points, sb.beats);
        $display("%0d passes cut a loop, %0d overran the store, %0d distance writes",
                 sb.looped_runs, sb.dropped_runs, sb.writes);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
